>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define FBR_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// prop must never hold outside reset
`define FBR_ASSERT_NEVER(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) !(prop)) else $error(msg);

`else

`define FBR_ASSERT(name, clk, rst_n, prop, msg)
`define FBR_ASSERT_NEVER(name, clk, rst_n, prop, msg)

`endif

`endif

>>> src/fbr_pkg.sv
// ----------------------------------------------------------------------------
// fbr_pkg
// Constants and codes of the framed byte receiver.
// ----------------------------------------------------------------------------
package fbr_pkg;

    // default geometry of the slot ring
    localparam int DEF_NUM_SLOTS   = 8;
    localparam int DEF_FRAME_BYTES = 32;

    // framing bytes and limits
    localparam logic [7:0] START_BYTE    = 8'hFF;
    localparam logic [7:0] END_BYTE      = 8'hFE;
    localparam int         MIN_END_BYTES = 16;

    // fixed field widths
    localparam int ACTION_W   = 2;
    localparam int BYTE_W     = 8;
    localparam int RD_INDEX_W = 5;
    localparam int S_TDATA_W  = 16;

    // beat kinds on the input channel
    typedef enum logic [ACTION_W-1:0] {
        ACT_BYTE    = 2'd0,
        ACT_READ    = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_NOP     = 2'd3
    } action_t;

    // per-slot state
    typedef enum logic [1:0] {
        SLOT_EMPTY   = 2'd0,
        SLOT_LOADING = 2'd1,
        SLOT_PENDING = 2'd2
    } slot_state_t;

endpackage

>>> src/framed_byte_receiver_with_sum_check.sv
// ----------------------------------------------------------------------------
// framed_byte_receiver_with_sum_check
// Collects delimited byte frames into a ring of slots and checks their sum.
// ----------------------------------------------------------------------------
// Takes one beat per clock unless the result path stalls, and returns exactly
// one result beat per input beat through stage 1 and the output register. A
// byte beat (0xFF starts a frame) is written into the load slot's area of a
// single-port-write block memory; the frame closes at FRAME_BYTES bytes or on
// 0xFE once at least 16 bytes are stored, and the 32-bit sum check uses a
// short history of the last four stored bytes, so it needs no extra memory
// read. Read beats fetch one byte of the oldest slot through the memory's
// registered read port. Release beats free the oldest slot if it holds an
// accepted frame. Frame memory has no reset; reading bytes that were never
// received gives unspecified data. Slot states reset to empty at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module framed_byte_receiver_with_sum_check
    import fbr_pkg::*;
#(
    parameter int  NUM_SLOTS   = DEF_NUM_SLOTS,
    parameter int  FRAME_BYTES = DEF_FRAME_BYTES,
    localparam int SLOT_W      = $clog2(NUM_SLOTS),
    localparam int M_FIELDS_W  = 3 + BYTE_W + SLOT_W,
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // rx_byte, read_index
    input  logic [ACTION_W-1:0]   s_tuser,   // action
    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // frame_done, frame_good, frame_slot,
                                             // read_byte, slot_pending
);

    localparam int POS_W     = $clog2(FRAME_BYTES);
    localparam int POS_CNT_W = $clog2(FRAME_BYTES + 1);
    localparam int ADDR_W    = SLOT_W + POS_W;
    localparam int MEM_DEPTH = 2 ** ADDR_W;
    localparam logic [POS_CNT_W-1:0] FRAME_LEN   = POS_CNT_W'(FRAME_BYTES);
    localparam logic [POS_CNT_W-1:0] MIN_END_LEN = POS_CNT_W'(MIN_END_BYTES);
    localparam logic [SLOT_W-1:0]    LAST_SLOT   = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [31:0]          DELIM_SUM   = 32'(START_BYTE) + 32'(END_BYTE);

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        next_slot = (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    slot_state_t            status_reg [NUM_SLOTS];
    slot_state_t            status_next [NUM_SLOTS];
    logic [SLOT_W-1:0]      load_slot_reg, load_slot_next;
    logic [SLOT_W-1:0]      proc_slot_reg, proc_slot_next;
    logic [POS_CNT_W-1:0]   pos_reg, pos_next;
    logic [15:0]            sum_reg, sum_next;
    logic [BYTE_W-1:0]      hist_reg [4];

    logic [BYTE_W-1:0]      store_mem [MEM_DEPTH];
    logic [BYTE_W-1:0]      rd_data_reg;

    logic                   p1_valid_reg;
    logic                   p1_done_reg;
    logic                   p1_good_reg;
    logic [SLOT_W-1:0]      p1_slot_reg;
    logic                   p1_rd_reg;
    logic                   p1_pend_reg;

    logic                   m_valid_reg;
    logic [M_TDATA_W-1:0]   m_data_reg, m_data_next;

    // ------------------------------------------------------------------------
    // input decode and handshake
    // ------------------------------------------------------------------------
    action_t                action;
    logic [BYTE_W-1:0]      rx_byte;
    logic [RD_INDEX_W-1:0]  read_index;
    logic                   s_fire;
    logic                   p1_move;

    assign action     = action_t'(s_tuser);
    assign rx_byte    = s_tdata[BYTE_W-1:0];
    assign read_index = s_tdata[BYTE_W +: RD_INDEX_W];

    assign p1_move  = !m_valid_reg || m_tready;
    assign s_tready = !p1_valid_reg || p1_move;
    assign s_fire   = s_tvalid && s_tready;

    // ------------------------------------------------------------------------
    // byte path: store, running sum, frame end and sum check
    // ------------------------------------------------------------------------
    logic                   start_byte;
    logic                   loading;
    logic                   do_store;
    logic                   frame_end;
    logic                   check_ok;
    logic                   do_release;
    logic                   rd_in_range;
    logic [POS_CNT_W-1:0]   pos_eff;
    logic [15:0]            sum_eff;
    logic [POS_CNT_W-1:0]   pos_inc;
    logic [15:0]            sum_inc;
    logic [9:0]             hist_sum;
    logic [31:0]            sent_val;
    logic [31:0]            calc_val;
    logic [ADDR_W-1:0]      wr_addr;
    logic [ADDR_W-1:0]      rd_addr;

    assign start_byte = (action == ACT_BYTE) && (rx_byte == START_BYTE);
    assign pos_eff    = start_byte ? '0 : pos_reg;
    assign sum_eff    = start_byte ? '0 : sum_reg;
    assign loading    = start_byte || (status_reg[load_slot_reg] == SLOT_LOADING);
    assign do_store   = s_fire && (action == ACT_BYTE) && loading && (pos_eff < FRAME_LEN);

    assign pos_inc = pos_eff + 1'b1;
    assign sum_inc = sum_eff + 16'(rx_byte);

    assign frame_end = do_store && ((pos_inc >= FRAME_LEN) ||
                                    ((rx_byte == END_BYTE) && (pos_inc >= MIN_END_LEN)));

    // check bytes are the four stored just before the closing byte, oldest lowest
    assign hist_sum = 10'(hist_reg[0]) + 10'(hist_reg[1]) + 10'(hist_reg[2])
                    + 10'(hist_reg[3]);
    assign sent_val = {hist_reg[3], hist_reg[2], hist_reg[1], hist_reg[0]};
    assign calc_val = 32'(sum_inc) - DELIM_SUM - 32'(hist_sum);
    assign check_ok = (calc_val == sent_val);

    assign wr_addr = {load_slot_reg, pos_eff[POS_W-1:0]};
    assign rd_addr = {proc_slot_reg, POS_W'(read_index)};

    assign rd_in_range = (32'(read_index) < 32'(FRAME_BYTES));
    assign do_release  = s_fire && (action == ACT_RELEASE) &&
                         (status_reg[proc_slot_reg] == SLOT_PENDING);

    // next slot states and pointers
    always_comb begin
        status_next    = status_reg;
        load_slot_next = load_slot_reg;
        proc_slot_next = proc_slot_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        if (do_store) begin
            pos_next = pos_inc;
            sum_next = sum_inc;
            status_next[load_slot_reg] = SLOT_LOADING;
            if (frame_end) begin
                if (check_ok) begin
                    status_next[load_slot_reg] = SLOT_PENDING;
                    load_slot_next = next_slot(load_slot_reg);
                end else begin
                    status_next[load_slot_reg] = SLOT_EMPTY;
                end
            end
        end
        if (do_release) begin
            status_next[proc_slot_reg] = SLOT_EMPTY;
            proc_slot_next = next_slot(proc_slot_reg);
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                status_reg[i] <= SLOT_EMPTY;
            end
            load_slot_reg <= '0;
            proc_slot_reg <= '0;
            pos_reg       <= '0;
            sum_reg       <= '0;
        end else begin
            status_reg    <= status_next;
            load_slot_reg <= load_slot_next;
            proc_slot_reg <= proc_slot_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
        end
    end

    // history of the last four stored bytes, newest in entry 3
    always_ff @(posedge aclk) begin
        if (do_store) begin
            hist_reg[0] <= hist_reg[1];
            hist_reg[1] <= hist_reg[2];
            hist_reg[2] <= hist_reg[3];
            hist_reg[3] <= rx_byte;
        end
    end

    // frame memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (do_store) begin
            store_mem[wr_addr] <= rx_byte;
        end
        if (s_fire && (action == ACT_READ)) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------------
    // result pipeline: stage 1 waits for read data, then the output register
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            p1_valid_reg <= s_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p1_done_reg <= frame_end;
            p1_good_reg <= frame_end && check_ok;
            p1_slot_reg <= frame_end ? load_slot_reg : '0;
            p1_rd_reg   <= (action == ACT_READ) && rd_in_range;
            p1_pend_reg <= (status_next[proc_slot_next] == SLOT_PENDING);
        end
    end

    // pack result fields, lowest first
    always_comb begin
        m_data_next                          = '0;
        m_data_next[0]                       = p1_done_reg;
        m_data_next[1]                       = p1_good_reg;
        m_data_next[2 +: SLOT_W]             = p1_slot_reg;
        m_data_next[2 + SLOT_W +: BYTE_W]    = p1_rd_reg ? rd_data_reg : '0;
        m_data_next[2 + SLOT_W + BYTE_W]     = p1_pend_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p1_move) begin
            m_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_move && p1_valid_reg) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `FBR_ASSERT(a_good_has_done, aclk, aresetn, p1_valid_reg && p1_good_reg |-> p1_done_reg, "good flag without frame end")
    `FBR_ASSERT(a_no_short_frame, aclk, aresetn, frame_end |-> (pos_inc >= MIN_END_LEN), "frame closed below minimum length")
    `FBR_ASSERT(a_load_adv, aclk, aresetn, (load_slot_reg != $past(load_slot_reg)) |-> $past(frame_end && check_ok), "load slot moved without an accepted frame")
    `FBR_ASSERT(a_proc_adv, aclk, aresetn, (proc_slot_reg != $past(proc_slot_reg)) |-> $past(do_release), "process slot moved without a release")
    `FBR_ASSERT_NEVER(a_read_and_store, aclk, aresetn, do_store && p1_rd_reg && s_fire && (action == ACT_READ), "store and read in one beat")

endmodule
